>>> src/tcce_pkg.sv
package tcce_pkg;

  // effective screen limits in text cells
  localparam int unsigned MAX_COLUMNS = 512;
  localparam int unsigned MAX_ROWS    = 512;

  localparam int unsigned CFG_W   = 10;
  localparam int unsigned COORD_W = 9;
  localparam int unsigned GLYPH_W = 7;
  localparam int unsigned RGB_W   = 24;

  // register reset values
  localparam logic [CFG_W-1:0] COLUMNS_RESET = CFG_W'(80);
  localparam logic [CFG_W-1:0] ROWS_RESET    = CFG_W'(25);

  // register indexes
  localparam logic CFG_COLUMNS = 1'b0;
  localparam logic CFG_ROWS    = 1'b1;

  // input op codes
  localparam logic [1:0] OP_BYTE      = 2'd0;
  localparam logic [1:0] OP_RESET_COL = 2'd1;
  localparam logic [1:0] OP_SET_FG    = 2'd2;
  localparam logic [1:0] OP_SET_BG    = 2'd3;

  // control bytes
  localparam logic [7:0] CH_DEL = 8'h7F;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_NL  = 8'h0A;
  localparam logic [GLYPH_W-1:0] GLYPH_SPACE = 7'h20;

  // result kinds
  localparam logic KIND_DRAW   = 1'b0;
  localparam logic KIND_SCROLL = 1'b1;

  localparam logic [RGB_W-1:0] RGB_GREY  = 24'hAAAAAA;
  localparam logic [RGB_W-1:0] RGB_BLACK = 24'h000000;

  localparam int unsigned PAL_SIZE = 20;
  localparam logic [RGB_W-1:0] PALETTE [PAL_SIZE] = '{
    24'h000000, 24'hAA0000, 24'h00AA00, 24'hAA5500,
    24'h0000AA, 24'hAA00AA, 24'h00AAAA, 24'hAAAAAA,
    24'hAAAAAA, 24'hAAAAAA, 24'h555555, 24'hFF5555,
    24'h55FF55, 24'hFFFF55, 24'h5555FF, 24'hFF55FF,
    24'h55FFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF
  };

  // what the back end has to do with one queued command
  typedef enum logic [2:0] {
    CLS_PRINT,
    CLS_DEL,
    CLS_BS,
    CLS_NL,
    CLS_RESET_COL,
    CLS_SET_FG,
    CLS_SET_BG
  } cls_t;

  typedef struct packed {
    cls_t               cls;
    logic [GLYPH_W-1:0] glyph;
    logic [RGB_W-1:0]   rgb;
  } cmd_t;

  typedef struct packed {
    logic               kind;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [GLYPH_W-1:0] glyph;
    logic [RGB_W-1:0]   fg;
    logic [RGB_W-1:0]   bg;
    logic               last;
  } res_t;

  function automatic logic [RGB_W-1:0] pal_rgb(input logic [7:0] idx);
    logic [RGB_W-1:0] rgb;
    rgb = RGB_BLACK;
    if (idx < 8'(PAL_SIZE)) begin
      rgb = PALETTE[idx[4:0]];
    end
    return rgb;
  endfunction

endpackage

>>> src/tcce_front.sv
module tcce_front (
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [23:0]      in_tdata,
  input  logic             q_full,
  output logic             q_push,
  output tcce_pkg::cmd_t   q_cmd
);

  logic [1:0] op;
  logic [7:0] ch;
  logic [7:0] cidx;

  assign op   = in_tdata[1:0];
  assign ch   = in_tdata[9:2];
  assign cidx = in_tdata[17:10];

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_cmd.glyph = ch[7] ? '0 : ch[6:0];
    q_cmd.rgb   = tcce_pkg::pal_rgb(cidx);
    q_cmd.cls   = tcce_pkg::CLS_PRINT;
    unique case (op)
      tcce_pkg::OP_BYTE: begin
        unique case (ch)
          tcce_pkg::CH_DEL: q_cmd.cls = tcce_pkg::CLS_DEL;
          tcce_pkg::CH_BS:  q_cmd.cls = tcce_pkg::CLS_BS;
          tcce_pkg::CH_NL:  q_cmd.cls = tcce_pkg::CLS_NL;
          default:          q_cmd.cls = tcce_pkg::CLS_PRINT;
        endcase
      end
      tcce_pkg::OP_RESET_COL: q_cmd.cls = tcce_pkg::CLS_RESET_COL;
      tcce_pkg::OP_SET_FG:    q_cmd.cls = tcce_pkg::CLS_SET_FG;
      tcce_pkg::OP_SET_BG:    q_cmd.cls = tcce_pkg::CLS_SET_BG;
      default:                q_cmd.cls = tcce_pkg::CLS_PRINT;
    endcase
  end

endmodule

>>> src/tcce_queue.sv
module tcce_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tcce_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output tcce_pkg::cmd_t head_cmd
);

  tcce_pkg::cmd_t mem_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_cmd   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> src/tcce_back.sv
module tcce_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic                        cfg_addr,
  input  logic [tcce_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                        head_valid,
  input  tcce_pkg::cmd_t              head_cmd,
  output logic                        pop,
  output logic                        res_valid,
  input  logic                        res_ready,
  output tcce_pkg::res_t              res
);

  localparam int unsigned CW = tcce_pkg::CFG_W;
  localparam int unsigned PW = tcce_pkg::COORD_W;

  logic [CW-1:0]     columns_r, columns_nxt;
  logic [CW-1:0]     rows_r, rows_nxt;
  logic [PW-1:0]     col_r, col_nxt;
  logic [PW-1:0]     row_r, row_nxt;
  logic [23:0]       fore_r, fore_nxt;
  logic [23:0]       back_r, back_nxt;
  logic              out_valid_r, out_valid_nxt;
  tcce_pkg::res_t    out_r, out_nxt;
  logic              pend_r, pend_nxt;

  logic [CW-1:0]     eff_cols;
  logic [CW-1:0]     eff_rows;
  logic [CW-1:0]     col_last_w;
  logic [CW-1:0]     bottom_w;
  logic [PW-1:0]     col_last;
  logic [PW-1:0]     bottom;
  logic [CW-1:0]     col_inc;
  logic              at_bottom;
  logic              slot_free;
  logic              needs_out;
  logic              take;
  tcce_pkg::res_t    scroll_res;

  always_comb begin
    eff_cols = columns_r;
    if (columns_r == '0) eff_cols = CW'(1);
    if (columns_r > CW'(tcce_pkg::MAX_COLUMNS)) eff_cols = CW'(tcce_pkg::MAX_COLUMNS);
    eff_rows = rows_r;
    if (rows_r == '0) eff_rows = CW'(1);
    if (rows_r > CW'(tcce_pkg::MAX_ROWS)) eff_rows = CW'(tcce_pkg::MAX_ROWS);
  end

  assign col_last_w = eff_cols - CW'(1);
  assign bottom_w   = eff_rows - CW'(1);
  assign col_last   = col_last_w[PW-1:0];
  assign bottom     = bottom_w[PW-1:0];
  assign col_inc    = {1'b0, col_r} + CW'(1);
  assign at_bottom  = (row_r >= bottom);
  assign slot_free  = !out_valid_r || res_ready;

  always_comb begin
    scroll_res      = '0;
    scroll_res.kind = tcce_pkg::KIND_SCROLL;
    scroll_res.last = 1'b1;
  end

  always_comb begin
    case (head_cmd.cls) inside
      tcce_pkg::CLS_PRINT, tcce_pkg::CLS_DEL: needs_out = 1'b1;
      tcce_pkg::CLS_NL:                       needs_out = at_bottom;
      default:                                needs_out = 1'b0;
    endcase
  end

  assign take = head_valid && !pend_r && (!needs_out || slot_free);
  assign pop  = take;

  always_comb begin
    columns_nxt   = columns_r;
    rows_nxt      = rows_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    fore_nxt      = fore_r;
    back_nxt      = back_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;

    if (cfg_we) begin
      if (cfg_addr == tcce_pkg::CFG_COLUMNS) columns_nxt = cfg_wdata;
      else rows_nxt = cfg_wdata;
    end

    if (slot_free) begin
      out_valid_nxt = 1'b0;
      if (pend_r) begin
        out_valid_nxt = 1'b1;
        out_nxt       = scroll_res;
        pend_nxt      = 1'b0;
      end
    end

    if (take) begin
      unique case (head_cmd.cls) inside
        tcce_pkg::CLS_PRINT: begin
          out_valid_nxt = 1'b1;
          out_nxt.kind  = tcce_pkg::KIND_DRAW;
          out_nxt.col   = col_r;
          out_nxt.row   = row_r;
          out_nxt.glyph = head_cmd.glyph;
          out_nxt.fg    = fore_r;
          out_nxt.bg    = back_r;
          out_nxt.last  = 1'b1;
          col_nxt       = col_inc[PW-1:0];
          if (col_inc >= eff_cols) begin
            col_nxt = '0;
            if (at_bottom) begin
              row_nxt      = bottom;
              out_nxt.last = 1'b0;
              pend_nxt     = 1'b1;
            end else begin
              row_nxt = row_r + PW'(1);
            end
          end
        end
        tcce_pkg::CLS_DEL, tcce_pkg::CLS_BS: begin
          if (col_r == '0) begin
            col_nxt = col_last;
            if (row_r != '0) row_nxt = row_r - PW'(1);
          end else begin
            col_nxt = col_r - PW'(1);
          end
          if (head_cmd.cls == tcce_pkg::CLS_DEL) begin
            out_valid_nxt = 1'b1;
            out_nxt.kind  = tcce_pkg::KIND_DRAW;
            out_nxt.col   = col_nxt;
            out_nxt.row   = row_nxt;
            out_nxt.glyph = tcce_pkg::GLYPH_SPACE;
            out_nxt.fg    = tcce_pkg::RGB_GREY;
            out_nxt.bg    = tcce_pkg::RGB_BLACK;
            out_nxt.last  = 1'b1;
          end
        end
        tcce_pkg::CLS_NL: begin
          col_nxt = '0;
          if (at_bottom) begin
            row_nxt       = bottom;
            out_valid_nxt = 1'b1;
            out_nxt       = scroll_res;
          end else begin
            row_nxt = row_r + PW'(1);
          end
        end
        tcce_pkg::CLS_RESET_COL: begin
          fore_nxt = tcce_pkg::RGB_GREY;
          back_nxt = tcce_pkg::RGB_BLACK;
        end
        tcce_pkg::CLS_SET_FG: fore_nxt = head_cmd.rgb;
        tcce_pkg::CLS_SET_BG: back_nxt = head_cmd.rgb;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r   <= tcce_pkg::COLUMNS_RESET;
      rows_r      <= tcce_pkg::ROWS_RESET;
      col_r       <= '0;
      row_r       <= '0;
      fore_r      <= tcce_pkg::RGB_GREY;
      back_r      <= tcce_pkg::RGB_BLACK;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      columns_r   <= columns_nxt;
      rows_r      <= rows_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      fore_r      <= fore_nxt;
      back_r      <= back_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign res_valid = out_valid_r;
  assign res       = out_r;

endmodule

>>> src/text_console_cursor_engine_unit.sv
// channel   direction  words                          sideband
// in_       slave      op, ch, color_index            none
// out_      master     glyph draw or scroll command    tuser kind, tlast last of item
// cfg_      write      columns (0), rows (1)           no read-back
//
// one word per cycle is sustained while no scroll is pending: a command leaves the queue each
// cycle that, if it gives a result, the output register is free or being drained
// a printable byte that wraps on the bottom row gives a draw then a scroll;
// the scroll is issued from the pending-scroll flag once the output register is free
// reset (synchronous, active low) homes the cursor, restores grey on black and
// loads 80 columns by 25 rows
// a stall on out_ fills the two-entry queue, then in_tready drops
module text_console_cursor_engine_unit (
  input  logic        clk,
  input  logic        rst_n,
  // input words
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // op [1:0], ch [9:2], color_index [17:10], zero fill
  // result words
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // cell_col, cell_row, glyph, fg_red, fg_green,
                                  // fg_blue, bg_red, bg_green, bg_blue, zero fill
  output logic        out_tuser,  // kind
  output logic        out_tlast,  // last result of this input word
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [9:0]  cfg_wdata
);

  // front end: decode and palette lookup
  tcce_pkg::cmd_t front_cmd;
  logic           front_push;
  logic           q_full;

  // queue head towards the back end
  logic           head_valid;
  tcce_pkg::cmd_t head_cmd;
  logic           head_pop;

  // back end result register
  logic           res_valid;
  tcce_pkg::res_t res;

  tcce_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (front_push),
    .q_cmd     (front_cmd)
  );

  // short queue so that the decoder and the cursor logic stall independently
  tcce_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (front_push),
    .push_cmd   (front_cmd),
    .full       (q_full),
    .pop        (head_pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // cursor, colours and screen size live in the back end
  tcce_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (head_pop),
    .res_valid  (res_valid),
    .res_ready  (out_tready),
    .res        (res)
  );

  // pack the result word, cell column in the lowest bits
  assign out_tvalid = res_valid;
  assign out_tuser  = res.kind;
  assign out_tlast  = res.last;
  assign out_tdata  = {7'b0,
                       res.bg[7:0], res.bg[15:8], res.bg[23:16],
                       res.fg[7:0], res.fg[15:8], res.fg[23:16],
                       res.glyph, res.row, res.col};

endmodule

>>> test/testbench.sv
module testbench;

  // quiet cycles allowed with no word moving on any port: covers the longest
  // sender gap, the longest receiver hold and the settling pause several times
  localparam int unsigned QUIET_LIMIT     = 1000;
  // cycles allowed for words that give no result to clear the queue
  localparam int unsigned SETTLE_CYCLES   = 16;
  localparam int unsigned RANDOM_PHASES   = 9;
  localparam int unsigned WORDS_PER_PHASE = 120;

  // palette entries used by reset colours and by delete
  localparam logic [7:0] IDX_DEFAULT_FG = 8'd7;
  localparam logic [7:0] IDX_DEFAULT_BG = 8'd0;

  // sixteen text colours plus two extra greys and two extra whites; anything above is black
  localparam int unsigned TEXT_PALETTE_LEN = 20;
  localparam logic [tcce_pkg::RGB_W-1:0] TEXT_PALETTE [TEXT_PALETTE_LEN] = '{
    24'h000000, 24'hAA0000, 24'h00AA00, 24'hAA5500,
    24'h0000AA, 24'hAA00AA, 24'h00AAAA, 24'hAAAAAA,
    24'hAAAAAA, 24'hAAAAAA, 24'h555555, 24'hFF5555,
    24'h55FF55, 24'hFFFF55, 24'h5555FF, 24'hFF55FF,
    24'h55FFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF
  };

  // one draw or scroll command as it leaves the block
  typedef struct packed {
    logic                         kind;
    logic [tcce_pkg::COORD_W-1:0] col;
    logic [tcce_pkg::COORD_W-1:0] row;
    logic [tcce_pkg::GLYPH_W-1:0] glyph;
    logic [tcce_pkg::RGB_W-1:0]   fg;
    logic [tcce_pkg::RGB_W-1:0]   bg;
    logic                         last;
  } glyph_cmd_t;

  localparam glyph_cmd_t NO_CMD = '0;

  // one line of the directed script: a screen resize or an input word,
  // the latter with its commands typed in where they are obvious
  typedef struct {
    bit         sets_screen;
    logic [9:0] cols;
    logic [9:0] rows;
    logic [1:0] op;
    logic [7:0] ch;
    logic [7:0] idx;
    bit         known;
    int         n_known;
    glyph_cmd_t res_a;
    glyph_cmd_t res_b;
  } script_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // op [1:0], ch [9:2], color_index [17:10], zero fill
  logic        out_tvalid;
  logic        out_tready;
  logic [79:0] out_tdata;  // cell_col, cell_row, glyph, fg r/g/b, bg r/g/b, zero fill
  logic        out_tuser;  // kind
  logic        out_tlast;
  logic        cfg_we;
  logic        cfg_addr;
  logic [9:0]  cfg_wdata;

  // console model: screen registers, cursor and colours
  logic [tcce_pkg::CFG_W-1:0] screen_cols_reg;
  logic [tcce_pkg::CFG_W-1:0] screen_rows_reg;
  int unsigned                cur_col;
  int unsigned                cur_row;
  logic [tcce_pkg::RGB_W-1:0] fore_colour;
  logic [tcce_pkg::RGB_W-1:0] back_colour;
  glyph_cmd_t                 step_res [2];
  int                         step_n;

  // commands still owed by the block, oldest first
  glyph_cmd_t awaited [$];

  // typed-in commands travel with the word they belong to
  bit         known_word;
  int         known_n;
  glyph_cmd_t known_res [2];

  script_row_t script [$];

  int n_errors     = 0;
  int n_words      = 0;
  int n_draws      = 0;
  int n_scrolls    = 0;
  int n_reg_writes = 0;
  int quiet_cycles = 0;
  int hold_left    = 0;
  bit tx_calm      = 1'b0;
  bit rx_calm      = 1'b0;

  text_console_cursor_engine_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------- model

  function automatic logic [tcce_pkg::RGB_W-1:0] palette_colour(logic [7:0] idx);
    if (idx >= TEXT_PALETTE_LEN) return 24'h000000;
    return TEXT_PALETTE[idx[4:0]];
  endfunction

  // zero acts as one, oversize acts as the maximum
  function automatic int unsigned clamp_dim(logic [tcce_pkg::CFG_W-1:0] v,
                                            int unsigned top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  function automatic glyph_cmd_t draw_at(int unsigned col, int unsigned row,
                                         logic [tcce_pkg::GLYPH_W-1:0] glyph,
                                         logic [tcce_pkg::RGB_W-1:0] fg,
                                         logic [tcce_pkg::RGB_W-1:0] bg,
                                         bit last);
    glyph_cmd_t c;
    c       = '0;
    c.kind  = tcce_pkg::KIND_DRAW;
    c.col   = tcce_pkg::COORD_W'(col);
    c.row   = tcce_pkg::COORD_W'(row);
    c.glyph = glyph;
    c.fg    = fg;
    c.bg    = bg;
    c.last  = last;
    return c;
  endfunction

  // scroll carries no cell and no colour
  function automatic glyph_cmd_t scroll_cmd(bit last);
    glyph_cmd_t c;
    c      = '0;
    c.kind = tcce_pkg::KIND_SCROLL;
    c.last = last;
    return c;
  endfunction

  function automatic void add_result(glyph_cmd_t c);
    step_res[step_n] = c;
    step_n++;
  endfunction

  // step back one cell, wrapping to the end of the row above
  function automatic void cursor_back();
    if (cur_col == 0) begin
      cur_col = clamp_dim(screen_cols_reg, tcce_pkg::MAX_COLUMNS) - 1;
      if (cur_row != 0) cur_row--;
    end else begin
      cur_col--;
    end
  endfunction

  // move down a row; on or below the bottom row pin the cursor and ask for a scroll
  function automatic bit cursor_down();
    int unsigned bottom;
    bottom = clamp_dim(screen_rows_reg, tcce_pkg::MAX_ROWS) - 1;
    if (cur_row >= bottom) begin
      cur_row = bottom;
      return 1'b1;
    end
    cur_row++;
    return 1'b0;
  endfunction

  // advance the console by one input word, leaving its commands in step_res
  function automatic void console_step(logic [1:0] op, logic [7:0] ch, logic [7:0] idx);
    step_n = 0;
    case (op)
      tcce_pkg::OP_RESET_COL: begin
        fore_colour = palette_colour(IDX_DEFAULT_FG);
        back_colour = palette_colour(IDX_DEFAULT_BG);
      end
      tcce_pkg::OP_SET_FG: fore_colour = palette_colour(idx);
      tcce_pkg::OP_SET_BG: back_colour = palette_colour(idx);
      default: begin
        if (ch == tcce_pkg::CH_DEL) begin
          cursor_back();
          add_result(draw_at(cur_col, cur_row, tcce_pkg::GLYPH_SPACE,
                             palette_colour(IDX_DEFAULT_FG),
                             palette_colour(IDX_DEFAULT_BG), 1'b0));
        end else if (ch == tcce_pkg::CH_BS) begin
          cursor_back();
        end else if (ch == tcce_pkg::CH_NL) begin
          if (cursor_down()) add_result(scroll_cmd(1'b0));
          cur_col = 0;
        end else begin
          // every other byte draws; codes above 127 become glyph zero
          add_result(draw_at(cur_col, cur_row, ch[7] ? 7'd0 : ch[6:0],
                             fore_colour, back_colour, 1'b0));
          cur_col++;
          if (cur_col >= clamp_dim(screen_cols_reg, tcce_pkg::MAX_COLUMNS)) begin
            cur_col = 0;
            if (cursor_down()) add_result(scroll_cmd(1'b0));
          end
        end
      end
    endcase
    if (step_n > 0) step_res[step_n-1].last = 1'b1;
  endfunction

  // ------------------------------------------------------------- checking

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endtask

  // register writes, accepted words and results all sampled at the edge
  always @(posedge clk) begin
    glyph_cmd_t got;
    glyph_cmd_t want;
    if (rst_n && cfg_we) begin
      if (cfg_addr == tcce_pkg::CFG_COLUMNS) screen_cols_reg = cfg_wdata;
      else screen_rows_reg = cfg_wdata;
      n_reg_writes++;
    end
    if (rst_n && in_tvalid && in_tready) begin
      // the model always runs so that its state keeps step
      console_step(in_tdata[1:0], in_tdata[9:2], in_tdata[17:10]);
      if (known_word) begin
        for (int k = 0; k < known_n; k++) awaited.push_back(known_res[k]);
      end else begin
        for (int k = 0; k < step_n; k++) awaited.push_back(step_res[k]);
      end
      n_words++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      got.kind  = out_tuser;
      got.col   = out_tdata[8:0];
      got.row   = out_tdata[17:9];
      got.glyph = out_tdata[24:18];
      got.fg    = {out_tdata[32:25], out_tdata[40:33], out_tdata[48:41]};
      got.bg    = {out_tdata[56:49], out_tdata[64:57], out_tdata[72:65]};
      got.last  = out_tlast;
      if (got.kind == tcce_pkg::KIND_SCROLL) n_scrolls++;
      else n_draws++;
      if (awaited.size() == 0) begin
        $error("result word with nothing expected: kind %0d", got.kind);
        n_errors++;
      end else begin
        want = awaited.pop_front();
        check_field("kind",     want.kind,         got.kind);
        check_field("cell_col", want.col,          got.col);
        check_field("cell_row", want.row,          got.row);
        check_field("glyph",    want.glyph,        got.glyph);
        check_field("fg_red",   want.fg[23:16],    got.fg[23:16]);
        check_field("fg_green", want.fg[15:8],     got.fg[15:8]);
        check_field("fg_blue",  want.fg[7:0],      got.fg[7:0]);
        check_field("bg_red",   want.bg[23:16],    got.bg[23:16]);
        check_field("bg_green", want.bg[15:8],     got.bg[15:8]);
        check_field("bg_blue",  want.bg[7:0],      got.bg[7:0]);
        check_field("last",     want.last,         got.last);
      end
    end
  end

  // watchdog on cycles where no word moves anywhere
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("no handshake for %0d cycles, %0d results outstanding",
               quiet_cycles, awaited.size());
      $display("text_console_cursor_engine_unit regression: fail");
      $finish;
    end
  end

  // receiver: mostly ready, short holds and the odd long one, calm phases without
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (rx_calm || $urandom_range(0, 99) < 70) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= 1'b0;
      hold_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 50)
                                                : $urandom_range(0, 3);
    end
  end

  // -------------------------------------------------------------- stimulus

  function automatic int gap_len();
    int k;
    if (tx_calm) return 0;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 85) return $urandom_range(1, 3);
    if (k < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // screen sizes: mostly tiny so that wraps and scrolls are frequent
  function automatic logic [9:0] pick_dim();
    int k;
    k = $urandom_range(0, 9);
    if (k < 6) return 10'($urandom_range(1, 6));
    if (k == 6) return 10'd0;
    if (k == 7) return ($urandom_range(0, 1) == 0) ? 10'd512 : 10'd1023;
    if (k == 8) return 10'($urandom_range(0, 1023));
    return 10'($urandom_range(7, 40));
  endfunction

  // valid stays high across back-to-back words: it is lowered only for a gap or a drain
  task automatic send_word(logic [1:0] op, logic [7:0] ch, logic [7:0] idx,
                           bit known, int n, glyph_cmd_t a, glyph_cmd_t b);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid    <= 1'b1;
    in_tdata     <= {6'b0, idx, ch, op};
    known_word   <= known;
    known_n      <= n;
    known_res[0] <= a;
    known_res[1] <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // sender holds off until every owed command is out, then lets the queue settle
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write enable stays high across both writes
  task automatic set_screen(bit do_cols, logic [9:0] cols, bit do_rows, logic [9:0] rows);
    if (do_cols) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= tcce_pkg::CFG_COLUMNS;
      cfg_wdata <= cols;
      @(posedge clk);
    end
    if (do_rows) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= tcce_pkg::CFG_ROWS;
      cfg_wdata <= rows;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic add_known(logic [1:0] op, logic [7:0] ch, logic [7:0] idx,
                           int n, glyph_cmd_t a, glyph_cmd_t b);
    script_row_t r;
    r             = '{default: '0};
    r.op          = op;
    r.ch          = ch;
    r.idx         = idx;
    r.known       = 1'b1;
    r.n_known     = n;
    r.res_a       = a;
    r.res_b       = b;
    script.push_back(r);
  endtask

  task automatic add_item(logic [1:0] op, logic [7:0] ch, logic [7:0] idx);
    script_row_t r;
    r     = '{default: '0};
    r.op  = op;
    r.ch  = ch;
    r.idx = idx;
    script.push_back(r);
  endtask

  task automatic add_screen(logic [9:0] cols, logic [9:0] rows);
    script_row_t r;
    r             = '{default: '0};
    r.sets_screen = 1'b1;
    r.cols        = cols;
    r.rows        = rows;
    script.push_back(r);
  endtask

  initial begin
    int         sel;
    int         k;
    logic [1:0] op;
    logic [7:0] ch;
    logic [7:0] idx;

    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    out_tready <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_addr   <= tcce_pkg::CFG_COLUMNS;
    cfg_wdata  <= '0;
    known_word <= 1'b0;
    known_n    <= 0;

    // state after reset: 80 by 25, cursor home, light grey on black
    screen_cols_reg = 10'd80;
    screen_rows_reg = 10'd25;
    cur_col         = 0;
    cur_row         = 0;
    fore_colour     = palette_colour(IDX_DEFAULT_FG);
    back_colour     = palette_colour(IDX_DEFAULT_BG);

    // directed script, reset screen first
    add_known(tcce_pkg::OP_BYTE, 8'h41, 8'h00, 1,
              draw_at(0, 0, 7'h41, tcce_pkg::RGB_GREY, tcce_pkg::RGB_BLACK, 1'b1),
              NO_CMD);
    // high codes draw glyph zero
    add_known(tcce_pkg::OP_BYTE, 8'hFF, 8'h00, 1,
              draw_at(1, 0, 7'h00, tcce_pkg::RGB_GREY, tcce_pkg::RGB_BLACK, 1'b1),
              NO_CMD);
    add_item(tcce_pkg::OP_BYTE, 8'h80, 8'h00);
    // a control byte with no special meaning prints
    add_item(tcce_pkg::OP_BYTE, 8'h00, 8'h00);
    // colour commands give nothing; indexes past the palette give black
    add_known(tcce_pkg::OP_SET_FG, 8'h00, 8'd19, 0, NO_CMD, NO_CMD);
    add_known(tcce_pkg::OP_SET_BG, 8'hFF, 8'hFF, 0, NO_CMD, NO_CMD);
    add_item(tcce_pkg::OP_SET_BG, 8'h00, 8'd20);
    add_item(tcce_pkg::OP_SET_BG, 8'h00, 8'd4);
    add_item(tcce_pkg::OP_SET_FG, 8'h00, 8'd12);
    add_item(tcce_pkg::OP_BYTE, 8'h7E, 8'h00);
    add_item(tcce_pkg::OP_BYTE, tcce_pkg::CH_BS, 8'h00);
    // delete erases in grey on black whatever the current colours
    add_item(tcce_pkg::OP_BYTE, tcce_pkg::CH_DEL, 8'h00);
    add_known(tcce_pkg::OP_RESET_COL, 8'h00, 8'h00, 0, NO_CMD, NO_CMD);
    add_item(tcce_pkg::OP_BYTE, tcce_pkg::CH_NL, 8'h00);
    // backspace at column zero goes to the end of the row above
    add_item(tcce_pkg::OP_BYTE, tcce_pkg::CH_BS, 8'h00);
    add_item(tcce_pkg::OP_BYTE, tcce_pkg::CH_DEL, 8'h00);
    // one-cell screen: cursor now lies outside it, so the draw lands there
    add_screen(10'd1, 10'd1);
    add_item(tcce_pkg::OP_BYTE, 8'h5A, 8'h00);
    add_known(tcce_pkg::OP_BYTE, tcce_pkg::CH_NL, 8'h00, 1, scroll_cmd(1'b1), NO_CMD);
    add_known(tcce_pkg::OP_BYTE, 8'h71, 8'h00, 2,
              draw_at(0, 0, 7'h71, tcce_pkg::RGB_GREY, tcce_pkg::RGB_BLACK, 1'b0),
              scroll_cmd(1'b1));
    add_item(tcce_pkg::OP_BYTE, tcce_pkg::CH_BS, 8'h00);
    // zero sizes behave as one
    add_screen(10'd0, 10'd0);
    add_item(tcce_pkg::OP_BYTE, tcce_pkg::CH_NL, 8'h00);
    // oversize clamps to 512
    add_screen(10'd1023, 10'd1023);
    add_item(tcce_pkg::OP_BYTE, tcce_pkg::CH_DEL, 8'h00);
    add_item(tcce_pkg::OP_BYTE, 8'h61, 8'h00);
    add_screen(10'd512, 10'd512);
    add_item(tcce_pkg::OP_SET_FG, 8'h00, 8'h55);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[r]) begin
      if (script[r].sets_screen) begin
        wait_drained();
        set_screen(1'b1, script[r].cols, 1'b1, script[r].rows);
      end else begin
        send_word(script[r].op, script[r].ch, script[r].idx, script[r].known,
                  script[r].n_known, script[r].res_a, script[r].res_b);
      end
    end

    // random phases: each resizes the screen while idle, sometimes one register only
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_drained();
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      sel     = $urandom_range(0, 3);
      set_screen(sel != 2, pick_dim(), sel != 1, pick_dim());
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        k = $urandom_range(0, 99);
        if (k < 6) op = tcce_pkg::OP_RESET_COL;
        else if (k < 14) op = tcce_pkg::OP_SET_FG;
        else if (k < 22) op = tcce_pkg::OP_SET_BG;
        else op = tcce_pkg::OP_BYTE;
        // mostly printable text with a sprinkling of line and edit controls
        k = $urandom_range(0, 99);
        if (k < 8) ch = tcce_pkg::CH_NL;
        else if (k < 14) ch = tcce_pkg::CH_BS;
        else if (k < 20) ch = tcce_pkg::CH_DEL;
        else if (k < 70) ch = 8'($urandom_range(32, 126));
        else ch = 8'($urandom_range(0, 255));
        idx = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 19));
        send_word(op, ch, idx, 1'b0, 0, NO_CMD, NO_CMD);
        // occasional full drain mid-phase
        if ($urandom_range(0, 199) == 0) wait_drained();
      end
    end

    wait_drained();
    $display("checked %0d input words giving %0d glyph draws and %0d scrolls",
             n_words, n_draws, n_scrolls);
    $display("%0d screen register writes over %0d random phases plus the directed script",
             n_reg_writes, RANDOM_PHASES);
    if (n_errors == 0 && awaited.size() == 0) begin
      $display("text_console_cursor_engine_unit regression: pass");
    end else begin
      $display("text_console_cursor_engine_unit regression: fail");
    end
    $finish;
  end

endmodule
